### design/hnsc_pkg.sv
// Shared types and constants for the NAL start-code scanner and parameter-set cache.
`timescale 1ns / 1ps

package hnsc_pkg;

    localparam logic CMD_STREAM = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic SET_SPS = 1'b0;
    localparam logic SET_PPS = 1'b1;

    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

    typedef enum logic [1:0] {
        CAP_NONE = 2'd0,
        CAP_SPS  = 2'd1,
        CAP_PPS  = 2'd2
    } cap_target_t;

    typedef struct packed {
        logic sps;
        logic pps;
        logic idr;
        logic trunc;
    } frame_flags_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_of_frame;
        logic       which_set;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic       is_read_reply;
        logic       has_sps;
        logic       has_pps;
        logic       has_idr;
        logic [8:0] sps_length;
        logic [8:0] pps_length;
        logic       truncated;
        logic [7:0] read_byte;
    } out_item_t;

endpackage

### design/hnsc_in_if.sv
// Valid/ready channel carrying command and stream items into the scanner.
`timescale 1ns / 1ps

interface hnsc_in_if;
    import hnsc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/hnsc_out_if.sv
// Valid/ready channel carrying reports and read replies out of the scanner.
`timescale 1ns / 1ps

interface hnsc_out_if;
    import hnsc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/h264_nal_scan_and_param_cache_top.sv
// Annex B start-code scanner with a cache for the latest SPS and PPS units.
//
// Usage: items arrive on in_ch. A stream item carries one frame byte; the
// transaction that carries last_of_frame returns one end-of-frame report on
// out_ch with the SPS/PPS/IDR flags, both stored lengths and the truncation
// flag. A read item returns one reply with the cached byte at read_index of
// the chosen store (zero at or past its length). Other stream bytes give no
// result.
// Throughput: one item per cycle while out_ch does not stall, set by the single
// write port and single read port of the byte store; the scan state updates in the accepting cycle.
// Path: a result passes through the read stage, which holds the registered
// store read, and then through the output register.
// When out_ch stalls, a result waits in the output register and a second in
// the read stage; in_ch.ready falls only once both are occupied.
// Reset clears the scan state and both stored lengths at once, so the stores
// read as empty; the byte store itself is not cleared and needs no sweep.
`timescale 1ns / 1ps

module h264_nal_scan_and_param_cache_top #(
    parameter int CACHE_BYTES = 256
) (
    input logic       clk,
    input logic       rst_n,
    hnsc_in_if.sink   in_ch,
    hnsc_out_if.source out_ch
);
    import hnsc_pkg::*;

    localparam int AW  = $clog2(CACHE_BYTES);
    localparam int CW  = $clog2(CACHE_BYTES + 6);
    localparam int LW  = $clog2(CACHE_BYTES + 1);
    localparam int IW  = (LW > 8) ? LW : 8;
    localparam int L9W = (LW > 9) ? LW : 9;

    localparam logic [CW-1:0] CACHE_C   = CW'(CACHE_BYTES);
    localparam logic [CW-1:0] COUNT_SAT = CW'(CACHE_BYTES + 5);

    // Scan and capture state.
    logic [1:0]    zero_run_reg, zero_run_next;
    logic          pend_reg, pend_next;
    logic          pend_four_reg, pend_four_next;
    cap_target_t   tgt_reg, tgt_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    frame_flags_t  flags_reg, flags_next;
    logic [LW-1:0] sps_len_reg, sps_len_next;
    logic [LW-1:0] pps_len_reg, pps_len_next;
    // Start-code length at the head of each store: the start code bytes are
    // implied by this bit rather than written into the store.
    logic          sps_pre4_reg, sps_pre4_next;
    logic          pps_pre4_reg, pps_pre4_next;

    // Byte store, one row per parameter set.
    logic [7:0]    store_mem [2][CACHE_BYTES];
    logic          wr_en;
    logic          wr_sel;
    logic [AW-1:0] wr_pos;
    logic [7:0]    mem_q_reg;

    // Read stage and output register.
    logic          s1_valid_reg, s1_valid_next;
    out_item_t     s1_item_reg;
    logic          s1_hit_reg;
    logic          s1_pref_reg;
    logic          s1_pbit_reg;
    out_item_t     s1_out;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg;

    logic          accept;
    logic          s1_move;
    logic          is_stream;
    logic          produce;
    out_item_t     result;
    frame_flags_t  rep_flags;

    logic [IW-1:0] idx_w;
    logic [IW-1:0] len_sel_w;
    logic          rd_hit;
    logic          rd_pre4;
    logic          rd_pref;
    logic          rd_pbit;
    logic [AW-1:0] rd_addr;

    function automatic logic [LW-1:0] clip_len(input logic [CW-1:0] total);
        logic [CW-1:0] c;
        c = (total > CACHE_C) ? CACHE_C : total;
        return c[LW-1:0];
    endfunction

    function automatic logic [8:0] len9(input logic [LW-1:0] len);
        logic [L9W-1:0] w;
        w = L9W'(len);
        return w[8:0];
    endfunction

    assign s1_move     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_move;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_stream   = (in_ch.data.command == CMD_STREAM);

    // Read-side lookup against the current lengths and prefix lengths.
    always_comb
    begin
        idx_w     = IW'(in_ch.data.read_index);
        len_sel_w = (in_ch.data.which_set == SET_PPS) ? IW'(pps_len_reg) : IW'(sps_len_reg);
        rd_hit    = idx_w < len_sel_w;
        rd_pre4   = (in_ch.data.which_set == SET_PPS) ? pps_pre4_reg : sps_pre4_reg;
        rd_pref   = in_ch.data.read_index < (rd_pre4 ? 8'd4 : 8'd3);
        rd_pbit   = in_ch.data.read_index == (rd_pre4 ? 8'd3 : 8'd2);
        rd_addr   = idx_w[AW-1:0];
    end

    // Stream byte processing, including unit finish on header and on frame end.
    always_comb
    begin
        logic [CW-1:0] sc;
        logic [CW-1:0] total;
        zero_run_next  = zero_run_reg;
        pend_next      = pend_reg;
        pend_four_next = pend_four_reg;
        tgt_next       = tgt_reg;
        cnt_next       = cnt_reg;
        flags_next     = flags_reg;
        sps_len_next   = sps_len_reg;
        pps_len_next   = pps_len_reg;
        sps_pre4_next  = sps_pre4_reg;
        pps_pre4_next  = pps_pre4_reg;
        wr_en          = 1'b0;
        wr_sel         = SET_SPS;
        wr_pos         = cnt_reg[AW-1:0];
        rep_flags      = flags_reg;
        sc             = pend_four_reg ? CW'(4) : CW'(3);
        total          = '0;

        if (accept && is_stream)
        begin
            if (pend_reg)
            begin
                // This byte is the header of the unit that follows the start code.
                if (tgt_reg != CAP_NONE)
                begin
                    total = (cnt_reg >= sc) ? cnt_reg - sc : '0;
                    if (total > CACHE_C)
                    begin
                        flags_next.trunc = 1'b1;
                    end
                    if (tgt_reg == CAP_SPS)
                    begin
                        sps_len_next = clip_len(total);
                    end
                    else
                    begin
                        pps_len_next = clip_len(total);
                    end
                end
                pend_next = 1'b0;
                tgt_next  = CAP_NONE;
                cnt_next  = '0;
                case (in_ch.data.data_byte[4:0])
                    NAL_TYPE_SPS:
                    begin
                        flags_next.sps = 1'b1;
                        tgt_next       = CAP_SPS;
                    end
                    NAL_TYPE_PPS:
                    begin
                        flags_next.pps = 1'b1;
                        tgt_next       = CAP_PPS;
                    end
                    NAL_TYPE_IDR:
                    begin
                        flags_next.idr = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (tgt_next != CAP_NONE)
                begin
                    cnt_next = sc + CW'(1);
                    wr_en    = 1'b1;
                    wr_sel   = (tgt_next == CAP_PPS) ? SET_PPS : SET_SPS;
                    wr_pos   = sc[AW-1:0];
                    if (tgt_next == CAP_PPS)
                    begin
                        pps_pre4_next = pend_four_reg;
                    end
                    else
                    begin
                        sps_pre4_next = pend_four_reg;
                    end
                end
                zero_run_next = (in_ch.data.data_byte == 8'd0) ? 2'd1 : 2'd0;
            end
            else
            begin
                if (tgt_reg != CAP_NONE)
                begin
                    wr_en  = cnt_reg < CACHE_C;
                    wr_sel = (tgt_reg == CAP_PPS) ? SET_PPS : SET_SPS;
                    if (cnt_reg < COUNT_SAT)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                if (in_ch.data.data_byte == 8'd0)
                begin
                    if (zero_run_reg != ZERO_RUN_MAX)
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                end
                else if (in_ch.data.data_byte == 8'd1 && zero_run_reg >= 2'd2)
                begin
                    pend_next      = 1'b1;
                    pend_four_next = (zero_run_reg == ZERO_RUN_MAX);
                    zero_run_next  = 2'd0;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
            end

            if (in_ch.data.last_of_frame)
            begin
                if (tgt_next != CAP_NONE)
                begin
                    if (cnt_next > CACHE_C)
                    begin
                        flags_next.trunc = 1'b1;
                    end
                    if (tgt_next == CAP_SPS)
                    begin
                        sps_len_next = clip_len(cnt_next);
                    end
                    else
                    begin
                        pps_len_next = clip_len(cnt_next);
                    end
                end
                rep_flags      = flags_next;
                zero_run_next  = 2'd0;
                pend_next      = 1'b0;
                tgt_next       = CAP_NONE;
                cnt_next       = '0;
                flags_next     = '0;
            end
        end
    end

    // Result of the accepted item, less the byte that the store read supplies.
    always_comb
    begin
        produce = !is_stream || in_ch.data.last_of_frame;
        result  = '0;
        if (!is_stream)
        begin
            result.is_read_reply = 1'b1;
            result.sps_length    = len9(sps_len_reg);
            result.pps_length    = len9(pps_len_reg);
        end
        else
        begin
            result.has_sps    = rep_flags.sps;
            result.has_pps    = rep_flags.pps;
            result.has_idr    = rep_flags.idr;
            result.sps_length = len9(sps_len_next);
            result.pps_length = len9(pps_len_next);
            result.truncated  = rep_flags.trunc;
        end
    end

    always_comb
    begin
        if (accept && produce)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // The waiting result picks up its byte as it moves to the output register.
    always_comb
    begin
        s1_out = s1_item_reg;
        if (!s1_hit_reg)
        begin
            s1_out.read_byte = 8'd0;
        end
        else if (s1_pref_reg)
        begin
            s1_out.read_byte = {7'd0, s1_pbit_reg};
        end
        else
        begin
            s1_out.read_byte = mem_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg  <= 2'd0;
            pend_reg      <= 1'b0;
            pend_four_reg <= 1'b0;
            tgt_reg       <= CAP_NONE;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            sps_len_reg   <= '0;
            pps_len_reg   <= '0;
            sps_pre4_reg  <= 1'b0;
            pps_pre4_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            zero_run_reg  <= zero_run_next;
            pend_reg      <= pend_next;
            pend_four_reg <= pend_four_next;
            tgt_reg       <= tgt_next;
            cnt_reg       <= cnt_next;
            flags_reg     <= flags_next;
            sps_len_reg   <= sps_len_next;
            pps_len_reg   <= pps_len_next;
            sps_pre4_reg  <= sps_pre4_next;
            pps_pre4_reg  <= pps_pre4_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Writes land at the accepting edge, so a later read always sees them.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_sel][wr_pos] <= in_ch.data.data_byte;
        end
        if (accept && !is_stream && rd_hit)
        begin
            mem_q_reg <= store_mem[in_ch.data.which_set][rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            s1_item_reg <= result;
            s1_hit_reg  <= rd_hit && !is_stream;
            s1_pref_reg <= rd_pref;
            s1_pbit_reg <= rd_pbit;
        end
        if (s1_move)
        begin
            out_item_reg <= s1_out;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_stream && in_ch.data.last_of_frame)
        |=> (tgt_reg == CAP_NONE && zero_run_reg == 2'd0 && !pend_reg && cnt_reg == '0))
        else $error("scan state not cleared at frame end");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(sps_len_reg) <= CACHE_C) && (CW'(pps_len_reg) <= CACHE_C))
        else $error("stored length beyond store size");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free slot");

    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.is_read_reply)
        |-> !(out_ch.data.has_sps || out_ch.data.has_pps || out_ch.data.has_idr
              || out_ch.data.truncated))
        else $error("read reply carries frame flags");
`endif

endmodule
